// ===== rtl/minhash_signature_lsh_store_core_defines.svh =====
// Assertion macros for the checker file.
`ifndef MINHASH_SIGNATURE_LSH_STORE_CORE_DEFINES_SVH
`define MINHASH_SIGNATURE_LSH_STORE_CORE_DEFINES_SVH

// Check that holds outside of reset.
`define MHLSH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that must also hold while reset is applied.
`define MHLSH_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mhlsh_pkg.sv =====
`default_nettype none

package mhlsh_pkg;

  // Table geometry
  localparam int NUM_HASHES = 16;
  localparam int NUM_DOCS   = 256;
  localparam int RANK_BITS  = 16;
  localparam int DOC_BITS   = 8;
  localparam int HASH_BITS  = 4;
  localparam int ENTRY_BITS = RANK_BITS + 1;

  // Port field widths
  localparam int MODE_BITS    = 2;
  localparam int CFG_BITS     = 5;
  localparam int COUNT_BITS   = 5;
  localparam int S_TDATA_BITS = 40;
  localparam int M_TDATA_BITS = 8;

  // Band arithmetic widths
  localparam int CNT_BITS  = $clog2(NUM_HASHES + 1);
  localparam int PROD_BITS = 2 * CNT_BITS;

  localparam logic [CFG_BITS-1:0] BANDS_RESET = CFG_BITS'(4);

  // Operation codes
  localparam logic [MODE_BITS-1:0] MODE_UPDATE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_COUNT  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BAND   = 2'd2;

  typedef logic [DOC_BITS-1:0] doc_t;

  typedef struct packed {
    logic                 valid;
    logic [RANK_BITS-1:0] rank;
  } entry_t;

  // One document's signature, one entry per hash row
  typedef entry_t [NUM_HASHES-1:0] word_t;

endpackage

`default_nettype wire

// ===== rtl/minhash_signature_lsh_store_core.sv =====
// MinHash signature store with LSH band test.
// Input channel s_*: one beat is one command, mode on s_tuser (0 min update,
// 1 equal count, 2 band test); doc_a, doc_b, hash_index and row_rank in s_tdata.
// Output channel m_*: exactly one result beat per command, entry_changed,
// equal_count and band_match in m_tdata; fields of other modes read zero.
// cfg_wr_en/cfg_wr_data set the band count; write only while the block is idle.
// A command passes the signature RAM read, the compare/write-back and the
// result stage in order, and its result is then held in the output
// register. One command is worked on at a time: no new command is accepted
// until the result stage has handed its result to the output register.
// Reset empties the whole table at once through a per-document valid flag
// (a document row not yet written reads as all entries empty), drops the
// output valid and sets the band count to 4.
// If the receiver stalls, the result waits in the output register; the block
// holds the next command in its result stage until the register frees up.
`default_nettype none

module minhash_signature_lsh_store_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [mhlsh_pkg::CFG_BITS-1:0]       cfg_wr_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [7:0] doc_a, [15:8] doc_b, [19:16] hash_index, [35:20] row_rank, rest zero
  input  logic [mhlsh_pkg::S_TDATA_BITS-1:0]   s_tdata,
  // [1:0] mode
  input  logic [mhlsh_pkg::MODE_BITS-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] entry_changed, [5:1] equal_count, [6] band_match, [7] zero
  output logic [mhlsh_pkg::M_TDATA_BITS-1:0]   m_tdata
);
  import mhlsh_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [1:0] state;

  // Band configuration, clamped and split into rows at write time
  logic [CNT_BITS-1:0] bands;
  logic [CNT_BITS-1:0] rows;
  logic [CNT_BITS-1:0] bands_next;
  logic [CNT_BITS-1:0] rows_next;

  // Command registers
  logic [MODE_BITS-1:0] mode;
  doc_t                 doc_a;
  doc_t                 doc_b;
  logic [HASH_BITS-1:0] hash_idx;
  logic [RANK_BITS-1:0] rank;
  logic                 row_ok_a;
  logic                 row_ok_b;

  // Per-document written flag
  logic [NUM_DOCS-1:0] row_valid;

  // Compare stage results
  logic [NUM_HASHES-1:0] eq;
  logic                  changed;

  logic    s_beat;
  doc_t    in_doc_a;
  doc_t    in_doc_b;
  word_t   rd_a;
  word_t   rd_b;
  word_t   word_a;
  word_t   word_b;
  word_t   wr_word;
  entry_t  old_entry;
  logic    docs_ok;
  logic    hash_ok;
  logic    changed_next;
  logic    ram_we;
  logic    out_free;
  logic    band_hit;
  logic [COUNT_BITS-1:0] count;
  logic [M_TDATA_BITS-1:0] res_word;

  assign s_tready = (state == S_IDLE);
  assign s_beat   = s_tvalid && s_tready;
  assign in_doc_a = s_tdata[7:0];
  assign in_doc_b = s_tdata[15:8];
  assign out_free = !m_tvalid || m_tready;

  // Clamp band count and find rows per band: largest r with r * bands <= NUM_HASHES
  always_comb begin
    if (cfg_wr_data == '0) begin
      bands_next = CNT_BITS'(1);
    end else if (CNT_BITS'(cfg_wr_data) > CNT_BITS'(NUM_HASHES)) begin
      bands_next = CNT_BITS'(NUM_HASHES);
    end else begin
      bands_next = CNT_BITS'(cfg_wr_data);
    end
    rows_next = CNT_BITS'(1);
    for (int r = 1; r <= NUM_HASHES; r++) begin
      if (PROD_BITS'(r) * PROD_BITS'(bands_next) <= PROD_BITS'(NUM_HASHES)) begin
        rows_next = CNT_BITS'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bands <= CNT_BITS'(BANDS_RESET);
      rows  <= CNT_BITS'(NUM_HASHES / 4);
    end else if (cfg_wr_en) begin
      bands <= bands_next;
      rows  <= rows_next;
    end
  end

  // Signature RAM, read addressed straight from the incoming beat
  mhlsh_sig_ram u_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (doc_a),
    .wr_data   (wr_word),
    .rd_addr_a (in_doc_a),
    .rd_addr_b (in_doc_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Capture the command
  always_ff @(posedge clk) begin
    if (s_beat) begin
      mode     <= s_tuser;
      doc_a    <= in_doc_a;
      doc_b    <= in_doc_b;
      hash_idx <= s_tdata[19:16];
      rank     <= s_tdata[35:20];
      row_ok_a <= row_valid[in_doc_a];
      row_ok_b <= row_valid[in_doc_b];
    end
  end

  // Compare and min update
  always_comb begin
    word_a    = row_ok_a ? rd_a : '0;
    word_b    = row_ok_b ? rd_b : '0;
    docs_ok   = ((DOC_BITS+1)'(doc_a) < (DOC_BITS+1)'(NUM_DOCS)) &&
                ((DOC_BITS+1)'(doc_b) < (DOC_BITS+1)'(NUM_DOCS));
    hash_ok   = (32'(hash_idx) < NUM_HASHES) &&
                ((DOC_BITS+1)'(doc_a) < (DOC_BITS+1)'(NUM_DOCS));
    old_entry = word_a[hash_idx];
    changed_next = hash_ok && (!old_entry.valid || (old_entry.rank > rank));
    wr_word   = word_a;
    wr_word[hash_idx] = '{valid: 1'b1, rank: rank};
    ram_we    = (state == S_CMP) && (mode == MODE_UPDATE) && changed_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_CMP) begin
      for (int h = 0; h < NUM_HASHES; h++) begin
        eq[h] <= (word_a[h] == word_b[h]);
      end
      changed <= changed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[doc_a] <= 1'b1;
    end
  end

  // Band test over the registered equality vector
  always_comb begin
    logic [PROD_BITS-1:0] lo;
    logic [PROD_BITS-1:0] hi_end;
    logic                 band_all;
    band_hit = 1'b0;
    for (int b = 0; b < NUM_HASHES; b++) begin
      lo       = PROD_BITS'(b) * PROD_BITS'(rows);
      hi_end   = lo + PROD_BITS'(rows);
      band_all = (CNT_BITS'(b) < bands);
      for (int h = 0; h < NUM_HASHES; h++) begin
        if ((PROD_BITS'(h) >= lo) && (PROD_BITS'(h) < hi_end) && !eq[h]) begin
          band_all = 1'b0;
        end
      end
      band_hit = band_hit | band_all;
    end
    count = COUNT_BITS'($countones(eq));
  end

  // Result word, fields of other modes stay zero
  always_comb begin
    res_word    = '0;
    res_word[0] = (mode == MODE_UPDATE) && changed;
    if ((mode == MODE_COUNT) && docs_ok) begin
      res_word[5:1] = count;
    end
    res_word[6] = (mode == MODE_BAND) && docs_ok && (doc_a != doc_b) && band_hit;
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_RES) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_beat) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RES) && out_free) begin
      m_tdata <= res_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhlsh_sig_ram.sv =====
`default_nettype none

module mhlsh_sig_ram (
  input  logic              clk,
  input  logic              wr_en,
  input  mhlsh_pkg::doc_t   wr_addr,
  input  mhlsh_pkg::word_t  wr_data,
  input  mhlsh_pkg::doc_t   rd_addr_a,
  input  mhlsh_pkg::doc_t   rd_addr_b,
  output mhlsh_pkg::word_t  rd_data_a,
  output mhlsh_pkg::word_t  rd_data_b
);
  import mhlsh_pkg::*;

  // One signature word per document
  word_t mem [NUM_DOCS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/mhlsh_checker.sv =====
`default_nettype none
`include "minhash_signature_lsh_store_core_defines.svh"

module mhlsh_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A stalled result beat holds
  `MHLSH_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

  // Reset empties the output register
  `MHLSH_ASSERT_RST(a_rst_out, rst |=> !m_tvalid, "result valid right after reset")

  // One command at a time: no back-to-back input beats
  `MHLSH_ASSERT(a_one_cmd, s_tvalid && s_tready |=> !s_tready, "input ready right after a beat")

  // A result is on the output once the command's result stage has loaded it
  `MHLSH_ASSERT(a_latency, s_tvalid && s_tready |=> ##2 m_tvalid, "result missing after command")

  // Only one mode's fields can be nonzero, padding stays zero
  `MHLSH_ASSERT(a_fields, m_tvalid |-> !m_tdata[7] && !(m_tdata[0] && (m_tdata[6:1] != 6'd0)) && !(m_tdata[6] && (m_tdata[5:1] != 5'd0)), "result mixes mode fields")

endmodule

bind minhash_signature_lsh_store_core mhlsh_checker u_mhlsh_checker (.*);

`default_nettype wire

// ===== tb/signature_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels and the band register, keeps its own copy of
// the signature table and compares every result beat against the oldest
// predicted answer.
module signature_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [mhlsh_pkg::CFG_BITS-1:0]     cfg_wr_data,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // [7:0] doc_a, [15:8] doc_b, [19:16] hash_index, [35:20] row_rank, rest zero
  input  logic [mhlsh_pkg::S_TDATA_BITS-1:0] s_tdata,
  // [1:0] mode
  input  logic [mhlsh_pkg::MODE_BITS-1:0]    s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] entry_changed, [5:1] equal_count, [6] band_match, [7] zero
  input  logic [mhlsh_pkg::M_TDATA_BITS-1:0] m_tdata,
  output int                                 fail_count,
  output int                                 pending
);
  import mhlsh_pkg::*;

  typedef struct packed {
    logic                  changed;
    logic [COUNT_BITS-1:0] count;
    logic                  match;
  } answer_t;

  word_t               sig_table [NUM_DOCS];
  logic [CFG_BITS-1:0] band_cfg = BANDS_RESET;
  answer_t             answer_q [$];
  int                  errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // two empty entries agree, an empty and a filled one never do
  function automatic logic rows_agree(word_t a, word_t b, int h);
    if (a[h].valid != b[h].valid) return 1'b0;
    if (!a[h].valid) return 1'b1;
    return a[h].rank == b[h].rank;
  endfunction

  // apply one command to the table copy and work out its answer
  task automatic predict_answer(input logic [MODE_BITS-1:0] mode, input doc_t da,
                                input doc_t db, input logic [HASH_BITS-1:0] hi,
                                input logic [RANK_BITS-1:0] rank,
                                output answer_t ans);
    int   cnt;
    int   bands;
    int   rows;
    logic all_eq;
    ans = '0;
    case (mode)
      MODE_UPDATE: begin
        if (!sig_table[da][hi].valid || sig_table[da][hi].rank > rank) begin
          sig_table[da][hi].valid = 1'b1;
          sig_table[da][hi].rank  = rank;
          ans.changed = 1'b1;
        end
      end
      MODE_COUNT: begin
        cnt = 0;
        for (int h = 0; h < NUM_HASHES; h++)
          if (rows_agree(sig_table[da], sig_table[db], h)) cnt++;
        ans.count = (cnt > 31) ? COUNT_BITS'(31) : COUNT_BITS'(cnt);
      end
      MODE_BAND: begin
        if (da != db) begin
          // zero bands acts as one, more bands than hashes saturate
          bands = int'(band_cfg);
          if (bands == 0) bands = 1;
          if (bands > NUM_HASHES) bands = NUM_HASHES;
          rows = NUM_HASHES / bands;
          for (int b = 0; b < bands; b++) begin
            all_eq = 1'b1;
            for (int h = b * rows; h < (b + 1) * rows; h++)
              all_eq &= rows_agree(sig_table[da], sig_table[db], h);
            if (all_eq) ans.match = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result beats first: a result always belongs to an older command
  always @(posedge clk) begin : watch_proc
    answer_t ans;
    answer_t want;
    if (rst) begin
      for (int d = 0; d < NUM_DOCS; d++) sig_table[d] = '0;
      band_cfg = BANDS_RESET;
      answer_q.delete();
    end else begin
      if (cfg_wr_en) band_cfg = cfg_wr_data;
      if (m_tvalid && m_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = answer_q.pop_front();
          check_field("entry_changed", want.changed, m_tdata[0]);
          check_field("equal_count", want.count, m_tdata[5:1]);
          check_field("band_match", want.match, m_tdata[6]);
          check_field("pad bit", 0, m_tdata[7]);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_answer(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[19:16],
                       s_tdata[35:20], ans);
        answer_q = {answer_q, ans};
      end
    end
    pending    <= answer_q.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mhlsh_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT_BEAT = 200;
  localparam int LONG_HOLD    = 80;
  localparam int POOL_SIZE    = 6;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [MODE_BITS-1:0] mode;
    doc_t                 doc_a;
    doc_t                 doc_b;
    logic [HASH_BITS-1:0] hash;
    logic [RANK_BITS-1:0] rank;
    int                   gap;
  } command_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0]     cfg_wr_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic [MODE_BITS-1:0]    s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;

  int       fail_count;
  int       pending;
  command_t cmd_q [$];
  int       queued_cnt = 0;
  int       accepted_cnt = 0;
  int       gap_left = -1;
  int       ready_wait = 0;
  int       hold_left = 0;
  int       beats = 0;
  int       cycles = 0;
  bit       calm = 1'b0;
  doc_t     pool [POOL_SIZE];
  int       phase_bands [10] = '{1, 16, 3, 5, 7, 0, 31, 17, 4, 2};

  minhash_signature_lsh_store_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  signature_checker sig_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial forever #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // command driver: idle gap before each beat, then hold until taken
  always @(posedge clk) begin : drive_proc
    command_t cur;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = -1;
    end else begin
      if (s_tvalid && s_tready) accepted_cnt++;
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          if (gap_left < 0) gap_left = cmd_q[0].gap;
          if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
          end else begin
            cur = cmd_q.pop_front();
            s_tdata  <= {4'b0, cur.rank, cur.hash, cur.doc_b, cur.doc_a};
            s_tuser  <= cur.mode;
            s_tvalid <= 1'b1;
            gap_left = -1;
          end
        end
      end
    end
  end

  // result receiver: random stall per beat, one long hold mid-run
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats++;
        ready_wait = calm ? 0 : $urandom_range(0, 4);
        if (beats == HOLD_AT_BEAT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_cmd(input logic [MODE_BITS-1:0] mode, input doc_t a, input doc_t b,
                           input logic [HASH_BITS-1:0] h, input logic [RANK_BITS-1:0] r);
    command_t c;
    c.mode  = mode;
    c.doc_a = a;
    c.doc_b = b;
    c.hash  = h;
    c.rank  = r;
    c.gap   = calm ? 0 : $urandom_range(0, 4);
    cmd_q = {cmd_q, c};
    queued_cnt++;
  endtask

  // wait until every command is taken and every answer is back
  task automatic drain();
    while (accepted_cnt != queued_cnt) @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_bands(input logic [CFG_BITS-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly pool traffic so entries collide; mirrored updates build matching bands
  task automatic run_phase(input int n, input logic [CFG_BITS-1:0] bands_val);
    int                   made;
    int                   pick;
    doc_t                 da;
    doc_t                 db;
    logic [HASH_BITS-1:0] hi;
    logic [RANK_BITS-1:0] rk;
    write_bands(bands_val);
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = doc_t'($urandom_range(0, 255));
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      da   = pool[$urandom_range(0, POOL_SIZE - 1)];
      db   = pool[$urandom_range(0, POOL_SIZE - 1)];
      hi   = HASH_BITS'($urandom_range(0, NUM_HASHES - 1));
      rk   = ($urandom_range(0, 3) == 0) ? RANK_BITS'($urandom_range(0, 65535))
                                         : RANK_BITS'($urandom_range(0, 31));
      if (pick < 30) begin
        queue_cmd(MODE_UPDATE, da, db, hi, rk);
        made++;
      end else if (pick < 50) begin
        queue_cmd(MODE_UPDATE, da, db, hi, rk);
        queue_cmd(MODE_UPDATE, db, da, hi, rk);
        made += 2;
      end else if (pick < 70) begin
        queue_cmd(MODE_COUNT, da, db, hi, rk);
        made++;
      end else if (pick < 90) begin
        queue_cmd(MODE_BAND, da, db, hi, rk);
        made++;
      end else begin
        // noise over the full field ranges, unused mode included
        queue_cmd(MODE_BITS'($urandom_range(0, 3)), doc_t'($urandom_range(0, 255)),
                  doc_t'($urandom_range(0, 255)), hi, RANK_BITS'($urandom_range(0, 65535)));
        made++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty documents agree everywhere; same document never band-matches
    queue_cmd(MODE_BAND, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_COUNT, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_COUNT, 8'd7, 8'd7, 4'd0, 16'd0);
    queue_cmd(MODE_BAND, 8'd7, 8'd7, 4'd0, 16'd0);
    // min update: empty, equal rank, smaller, larger
    queue_cmd(MODE_UPDATE, 8'd0, 8'd255, 4'd0, 16'hFFFF);
    queue_cmd(MODE_UPDATE, 8'd0, 8'd255, 4'd0, 16'hFFFF);
    queue_cmd(MODE_UPDATE, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_UPDATE, 8'd0, 8'd255, 4'd0, 16'd1);
    queue_cmd(MODE_UPDATE, 8'd255, 8'd0, 4'd15, 16'd0);
    queue_cmd(MODE_UPDATE, 8'd255, 8'd0, 4'd15, 16'hFFFF);
    queue_cmd(MODE_COUNT, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_BAND, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_UNUSED, 8'd255, 8'd255, 4'd15, 16'hFFFF);
    queue_cmd(MODE_UPDATE, 8'd255, 8'd0, 4'd0, 16'd0);
    queue_cmd(MODE_UPDATE, 8'd0, 8'd255, 4'd15, 16'd0);
    // zero bands acts as a single band over all rows
    write_bands(5'd0);
    queue_cmd(MODE_BAND, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_UPDATE, 8'd0, 8'd255, 4'd8, 16'd5);
    queue_cmd(MODE_BAND, 8'd0, 8'd255, 4'd0, 16'd0);
    queue_cmd(MODE_COUNT, 8'd0, 8'd255, 4'd0, 16'd0);
    // too many bands saturate to one row each
    write_bands(5'd31);
    queue_cmd(MODE_BAND, 8'd0, 8'd255, 4'd0, 16'd0);
    write_bands(5'd16);
    queue_cmd(MODE_BAND, 8'd0, 8'd255, 4'd0, 16'd0);
    write_bands(5'd17);
    queue_cmd(MODE_BAND, 8'd255, 8'd0, 4'd0, 16'd0);

    // random phases, one with no idling on either side
    for (int p = 0; p < 10; p++) begin
      calm = (p == 4);
      run_phase(50, CFG_BITS'(phase_bands[p]));
    end
    calm = 1'b0;

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
